FILE: hdl/dq_pkg.sv
// Package for the double-ended queue: command and status codes and the
// field types shared by the queue logic.
// No dependencies.
package dq_pkg;

  typedef logic [2:0] cmd_t;
  typedef logic [1:0] status_t;

  localparam cmd_t CMD_PUSH_FRONT = 3'd0;
  localparam cmd_t CMD_PUSH_REAR  = 3'd1;
  localparam cmd_t CMD_POP_FRONT  = 3'd2;
  localparam cmd_t CMD_POP_REAR   = 3'd3;
  localparam cmd_t CMD_LIST       = 3'd4;

  localparam status_t STAT_OK         = 2'd0;
  localparam status_t STAT_UNDERFLOW  = 2'd1;
  localparam status_t STAT_FULL       = 2'd2;
  localparam status_t STAT_LIST_EMPTY = 2'd3;

  localparam int DATA_W = 32;

endpackage

FILE: hdl/double_ended_queue.sv
// Double-ended queue held as a ring in one synchronous memory, with front
// pointer, occupancy count, read sequencer and a registered result stage.
// Depends on dq_pkg.
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall  in_cmd, in_value
//   out_      output     out_valid / out_stall out_status, out_data, out_last
//
// A push, a refused push, an underflow or a list of an empty queue gives its
// result in the output register in the cycle after the transaction.
// A pop reads its entry into the read data register and then loads it into
// the output register, because the entry memory has a registered read port.
// A list reads its first entry the same way and then hands on one
// entry per cycle while the output is not stalled; DEPTH entries at most.
// A new transaction is taken once the last result of the previous one has
// been loaded into the output register and that register is free.
// Reset empties the queue at once; entries are not cleared.
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  cmd_t                     in_cmd,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output status_t                  out_status,
  output logic signed [DATA_W-1:0] out_data,
  output logic                     out_last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SEND = 1'b1;

  logic                     state_r, state_nxt;
  logic [AW-1:0]            head_r, head_nxt;
  logic [CW-1:0]            occ_r, occ_nxt;
  logic [AW-1:0]            k_r, k_nxt;
  logic [AW-1:0]            end_r, end_nxt;
  logic [AW-1:0]            rd_ptr_r, rd_ptr_nxt;

  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic signed [DATA_W-1:0] out_data_r, out_data_nxt;
  logic                     out_last_r, out_last_nxt;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;

  logic                     rd_en, wr_en;
  logic [AW-1:0]            wr_addr;
  logic                     out_load;
  logic                     out_free, in_acc;
  logic                     is_full, is_empty;
  logic [SW-1:0]            rear_sum, tail_sum;
  logic [AW-1:0]            rear_pos, tail_pos;
  logic [AW-1:0]            head_inc, head_dec, rd_ptr_inc;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign is_full  = (occ_r == CW'(DEPTH));
  assign is_empty = (occ_r == '0);

  // Ring positions: the free slot after the rear and the rear entry itself.
  assign rear_sum = {1'b0, head_r} + SW'(occ_r);
  assign rear_pos = (rear_sum >= SW'(DEPTH)) ? AW'(rear_sum - SW'(DEPTH))
                                             : AW'(rear_sum);
  assign tail_sum = rear_sum - SW'(1);
  assign tail_pos = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH))
                                             : AW'(tail_sum);

  assign head_inc   = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign head_dec   = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;
  assign rd_ptr_inc = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    occ_nxt        = occ_r;
    k_nxt          = k_r;
    end_nxt        = end_r;
    rd_ptr_nxt     = rd_ptr_r;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = rear_pos;
    out_load       = 1'b0;
    out_status_nxt = STAT_OK;
    out_data_nxt   = '0;
    out_last_nxt   = 1'b1;

    if (state_r == S_IDLE) begin
      if (in_acc) begin
        case (in_cmd)
          CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
            out_load = 1'b1;
            if (is_full) begin
              out_status_nxt = STAT_FULL;
            end else begin
              wr_en   = 1'b1;
              occ_nxt = occ_r + 1'b1;
              if (in_cmd == CMD_PUSH_FRONT) begin
                head_nxt = head_dec;
                wr_addr  = head_dec;
              end
            end
          end
          CMD_POP_FRONT, CMD_POP_REAR: begin
            if (is_empty) begin
              out_load       = 1'b1;
              out_status_nxt = STAT_UNDERFLOW;
            end else begin
              rd_en     = 1'b1;
              occ_nxt   = occ_r - 1'b1;
              k_nxt     = '0;
              end_nxt   = '0;
              state_nxt = S_SEND;
              if (in_cmd == CMD_POP_FRONT) begin
                rd_ptr_nxt = head_r;
                head_nxt   = head_inc;
              end else begin
                rd_ptr_nxt = tail_pos;
              end
            end
          end
          CMD_LIST: begin
            if (is_empty) begin
              out_load       = 1'b1;
              out_status_nxt = STAT_LIST_EMPTY;
            end else begin
              rd_en      = 1'b1;
              rd_ptr_nxt = head_r;
              k_nxt      = '0;
              end_nxt    = AW'(occ_r - 1'b1);
              state_nxt  = S_SEND;
            end
          end
          default: begin
            // Unused command codes are taken and dropped.
          end
        endcase
      end
    end else begin
      // The read data register holds entry k; hand it on and fetch the next.
      if (out_free) begin
        out_load     = 1'b1;
        out_data_nxt = rd_data_r;
        out_last_nxt = (k_r == end_r);
        if (k_r == end_r) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt      = k_r + 1'b1;
          rd_ptr_nxt = rd_ptr_inc;
          rd_en      = 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      occ_r       <= '0;
      k_r         <= '0;
      end_r       <= '0;
      rd_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      k_r         <= k_nxt;
      end_r       <= end_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_data_r   <= out_data_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_ptr_nxt];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(DEPTH))
    else $error("occupancy exceeds the store depth");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_cmd == CMD_PUSH_FRONT || in_cmd == CMD_PUSH_REAR) && !is_full)
    |=> (occ_r == $past(occ_r) + 1'b1))
    else $error("accepted push did not grow the queue by one");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_cmd == CMD_POP_FRONT || in_cmd == CMD_POP_REAR) && !is_empty)
    |=> (occ_r == $past(occ_r) - 1'b1))
    else $error("accepted pop did not shrink the queue by one");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEND) |-> (k_r <= end_r))
    else $error("list walk ran past the rear entry");

  a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (state_r == S_SEND))
    else $error("non-final result outside a list walk");

endmodule
